[design/isolated_boundary_cell_clean_top_assert.svh]
// Assertion macros shared by the checker of the boundary cell cleaner.
// Both expect the clock to be called i_clk; IBCC_ASSERT also expects the reset i_rst_n.
`ifndef ISOLATED_BOUNDARY_CELL_CLEAN_TOP_ASSERT_SVH
`define ISOLATED_BOUNDARY_CELL_CLEAN_TOP_ASSERT_SVH

// Property that is checked only outside of reset.
`define IBCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define IBCC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/ibcc_pkg.sv]
`timescale 1ns / 1ps

package ibcc_pkg;

    localparam int MAT_W            = 16;
    localparam int ROW_W            = 11;
    localparam int CFG_ROWS_W       = 11;
    localparam int CFG_COLS_W       = 11;
    localparam int CFG_MARGIN_W     = 3;
    localparam int ROWS_CAP         = 1024;
    localparam int MAX_COLS_DEFAULT = 1024;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN = 2'd2;

    localparam logic MODE_CELL  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [MAT_W-1:0] MAT_EMPTY = 16'd0;
    localparam logic [MAT_W-1:0] MAT_FLUID = 16'd1;

    typedef struct packed {
        logic             mode;
        logic [MAT_W-1:0] material;
    } t_in_item;

    typedef struct packed {
        logic [MAT_W-1:0] cell_value;
        logic             was_cleared;
        logic             last_cell;
    } t_out_item;

    // Control of a row delay line.
    typedef struct packed {
        logic shift;
        logic restart;
    } t_ld_ctrl;

endpackage

[design/isolated_boundary_cell_clean_top.sv]
`timescale 1ns / 1ps

// Isolated boundary cell cleaner.
// The input channel carries a material map in raster order, margin ring
// included, one cell per transaction (mode cell). A row is the interior
// width plus twice the margin. The output channel returns each cell after
// cleaning: a non-empty, non-fluid interior cell with no fluid neighbor
// comes out as 0 with was_cleared set; last_cell marks the final cell.
// A cell is emitted in the transaction that brings the cell one row and
// one column after it; after the whole map, one flush transaction per
// pending cell drains the rest (a row plus one cell). Cells after the map
// is complete and flushes with nothing pending produce no result.
// One transaction is taken per cycle unless the input stalls; a result
// is registered before it reaches the output. Two row delay lines in
// block memory hold the window. A map of a single row stalls the input
// for a pad shift when it completes. Any register write restarts
// the frame. Reset clears the counters and the output stage; registers
// return to one row, one column and no margin. When the receiver stalls,
// one more result is held in a skid entry, then the input stalls.
module isolated_boundary_cell_clean_top import ibcc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall
);

    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int GW   = ((CW > CFG_COLS_W) ? CW : CFG_COLS_W) + 1;
    localparam int MMAX = (MAX_COLS - 1) / 2;
    localparam logic [GW-1:0] MMAX_G = GW'(MMAX);
    localparam logic [GW-1:0] MAXC_G = GW'(MAX_COLS);

    // Configuration registers
    logic [CFG_ROWS_W-1:0]   r_irows;
    logic [CFG_COLS_W-1:0]   r_icols;
    logic [CFG_MARGIN_W-1:0] r_margin;
    logic                    cfg_write;
    logic [REG_IDX_W-1:0]    reg_idx;

    // Geometry
    logic [CFG_MARGIN_W-1:0] g_m;
    logic [GW-1:0]           margin_g;
    logic [GW-1:0]           m2_g;
    logic [GW-1:0]           cmax_g;
    logic [GW-1:0]           icols_g;
    logic [GW-1:0]           cols_g;
    logic [CW-1:0]           g_w;
    logic [CW-1:0]           g_colhi;
    logic [ROW_W-1:0]        g_rows;
    logic [ROW_W-1:0]        g_h;
    logic [ROW_W-1:0]        g_rowhi;

    // Scan state
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_erow;
    logic [CW-1:0]    r_ecol;
    logic             r_padded;

    // Window taps around the emitted cell
    logic             r_t1, r_t2;
    logic [MAT_W-1:0] r_m1;
    logic             r_m2;
    logic             r_b1, r_b2;
    logic [MAT_W-1:0] mid_val;
    logic             top_f;
    logic             mid_f;
    logic             new_f;
    logic [MAT_W-1:0] new_val;

    logic      accept, is_flush, complete, need_pad;
    logic      take_cell, take_flush, shift, early_ok, emit, last, restart;
    logic      up, down, left, right, nb_fluid, interior, clear;
    logic      skid_full;
    t_ld_ctrl  ld_ctrl;
    t_out_item result;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irows  <= CFG_ROWS_W'(1);
            r_icols  <= CFG_COLS_W'(1);
            r_margin <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ROWS:   r_irows  <= pwdata[CFG_ROWS_W-1:0];
                REG_COLS:   r_icols  <= pwdata[CFG_COLS_W-1:0];
                REG_MARGIN: r_margin <= pwdata[CFG_MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROWS:   prdata = APB_DATA_W'(r_irows);
            REG_COLS:   prdata = APB_DATA_W'(r_icols);
            REG_MARGIN: prdata = APB_DATA_W'(r_margin);
            default:    prdata = '0;
        endcase
    end

    // ---------------- geometry ----------------
    // The margin is limited so that a row fits the line store, and the
    // column count is limited by what the margin leaves.
    assign margin_g = GW'(r_margin);
    assign g_m      = (margin_g > MMAX_G) ? CFG_MARGIN_W'(MMAX_G) : r_margin;
    assign m2_g     = GW'(g_m) << 1;
    assign cmax_g   = MAXC_G - m2_g;
    assign icols_g  = GW'(r_icols);
    assign cols_g   = (r_icols == '0) ? GW'(1) :
                      ((icols_g > cmax_g) ? cmax_g : icols_g);
    assign g_w      = CW'(cols_g + m2_g);
    assign g_colhi  = CW'(cols_g + GW'(g_m));
    assign g_rows   = (r_irows == '0) ? ROW_W'(1) :
                      ((ROW_W'(r_irows) > ROW_W'(ROWS_CAP)) ? ROW_W'(ROWS_CAP)
                                                            : ROW_W'(r_irows));
    assign g_h      = g_rows + ROW_W'({g_m, 1'b0});
    assign g_rowhi  = g_rows + ROW_W'(g_m);

    // ---------------- control ----------------
    assign accept     = i_in_valid && !o_in_stall;
    assign is_flush   = (i_in_data.mode == MODE_FLUSH);
    assign complete   = (r_row >= g_h);
    // A single-row map ends one shift short of the window alignment that
    // the flushes expect, so one empty cell is shifted in on its own.
    assign need_pad   = complete && (g_h == ROW_W'(1)) && !r_padded;
    assign take_cell  = accept && !is_flush && !complete;
    assign take_flush = accept && is_flush && complete;
    assign shift      = take_cell || take_flush || need_pad;
    assign early_ok   = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
    assign emit       = take_flush || (take_cell && early_ok);
    assign last       = (r_erow == g_h - ROW_W'(1)) && (r_ecol == g_w - CW'(1));
    assign restart    = cfg_write || (emit && last);
    assign o_in_stall = skid_full || need_pad;

    assign new_val = take_cell ? i_in_data.material : MAT_EMPTY;
    assign new_f   = (new_val == MAT_FLUID);
    assign mid_f   = (mid_val == MAT_FLUID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_erow   <= '0;
            r_ecol   <= '0;
            r_padded <= 1'b0;
        end else if (restart) begin
            r_row    <= '0;
            r_col    <= '0;
            r_erow   <= '0;
            r_ecol   <= '0;
            r_padded <= 1'b0;
        end else begin
            if (take_cell) begin
                if (r_col == g_w - CW'(1)) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (emit) begin
                if (r_ecol == g_w - CW'(1)) begin
                    r_ecol <= '0;
                    r_erow <= r_erow + ROW_W'(1);
                end else begin
                    r_ecol <= r_ecol + CW'(1);
                end
            end
            if (need_pad) begin
                r_padded <= 1'b1;
            end
        end
    end

    // ---------------- window ----------------
    assign ld_ctrl.shift   = shift;
    assign ld_ctrl.restart = restart;

    ibcc_line_delay #(
        .DW    (MAT_W),
        .DEPTH (MAX_COLS)
    ) u_mid_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ld_ctrl),
        .i_len   (g_w),
        .i_data  (new_val),
        .o_data  (mid_val)
    );

    ibcc_line_delay #(
        .DW    (1),
        .DEPTH (MAX_COLS)
    ) u_top_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ld_ctrl),
        .i_len   (g_w),
        .i_data  (mid_f),
        .o_data  (top_f)
    );

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_b2 <= r_b1;
            r_b1 <= new_f;
            r_m2 <= (r_m1 == MAT_FLUID);
            r_m1 <= mid_val;
            r_t2 <= r_t1;
            r_t1 <= top_f;
        end
    end

    // ---------------- cleaning rule ----------------
    // Taps from before the frame or across a row edge are masked by the
    // position of the emitted cell.
    assign up    = (r_erow != '0);
    assign down  = (r_erow != g_h - ROW_W'(1));
    assign left  = (r_ecol != '0);
    assign right = (r_ecol != g_w - CW'(1));

    assign nb_fluid = (up && left && r_t2) || (up && r_t1) || (up && right && top_f) ||
                      (left && r_m2) || (right && mid_f) ||
                      (down && left && r_b2) || (down && r_b1) || (down && right && new_f);

    assign interior = (r_erow >= ROW_W'(g_m)) && (r_erow < g_rowhi) &&
                      (r_ecol >= CW'(g_m)) && (r_ecol < g_colhi);
    assign clear    = interior && (r_m1 != MAT_EMPTY) && (r_m1 != MAT_FLUID) && !nb_fluid;

    assign result.cell_value  = clear ? MAT_EMPTY : r_m1;
    assign result.was_cleared = clear;
    assign result.last_cell   = last;

    ibcc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (result),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

[design/ibcc_line_delay.sv]
`timescale 1ns / 1ps

// Delays a stream by a run-time length of 1 to DEPTH shifts. o_data shows
// the entry that leaves the line at the next shift.
module ibcc_line_delay import ibcc_pkg::*; #(
    parameter int DW    = MAT_W,
    parameter int DEPTH = MAX_COLS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ld_ctrl                     i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]   i_len,
    input  logic [DW-1:0]                i_data,
    output logic [DW-1:0]                o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic [DW-1:0] r_rd;
    logic [DW-1:0] r_last;
    logic          wrap;

    assign wrap  = (LW'(r_ptr) == i_len - LW'(1));
    assign n_ptr = wrap ? '0 : r_ptr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_ctrl.restart) begin
            r_ptr <= '0;
        end else if (i_ctrl.shift) begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_mem[r_ptr] <= i_data;
        end
    end

    // Prefetch the entry for the next shift. With a length of one the
    // read and write addresses meet, so that case takes the last input.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_rd   <= r_mem[n_ptr];
            r_last <= i_data;
        end
    end

    assign o_data = (i_len == LW'(1)) ? r_last : r_rd;

endmodule

[design/ibcc_skid.sv]
`timescale 1ns / 1ps

// Output register with a skid entry, so that the stall seen upstream is a
// register and not a path from the downstream stall.
module ibcc_skid import ibcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_skid_valid;
    t_out_item r_skid_data;
    logic      load_out;
    logic      load_skid;

    assign load_out  = !r_out_valid || !i_stall;
    assign load_skid = !r_skid_valid && i_push && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= r_skid_valid || i_push;
            end
            if (r_skid_valid) begin
                if (!i_stall) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (load_skid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end
        if (load_skid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

[design/ibcc_checker.sv]
`timescale 1ns / 1ps
`include "isolated_boundary_cell_clean_top_assert.svh"

module ibcc_checker import ibcc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // Reset leaves no result and no stall behind.
    `IBCC_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset left a transaction pending")

    `IBCC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")

    // A new result always comes from an input transaction in the cycle before.
    `IBCC_ASSERT(a_out_cause, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall), "result without an input transaction")

    // With the output free, a stall of the input is always lifted right after it is raised.
    `IBCC_ASSERT(a_stall_short, o_in_stall && !i_out_stall |=> !o_in_stall, "input stalled for two cycles with output free")

endmodule

bind isolated_boundary_cell_clean_top ibcc_checker u_ibcc_checker (.*);
